// ===== rtl/core/mbc_pkg.sv =====
package mbc_pkg;

    localparam int PAIRS = 15;
    localparam int VERTS = 6;
    localparam int LANES = PAIRS + 1;
    localparam int CNT_W = 3;
    localparam int IN_W  = PAIRS * CNT_W;

    typedef logic [VERTS-1:0] t_vset;
    typedef logic [PAIRS-1:0] t_emask;
    typedef logic [2:0]       t_vidx;

    localparam t_vset ALL_VERTS = {VERTS{1'b1}};
    localparam t_vset ROOT_VERT = t_vset'(1);

    // Endpoints of each vertex pair, in lexicographic pair order.
    localparam t_vidx PAIR_LO [PAIRS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2,
        3'd3, 3'd3,
        3'd4
    };
    localparam t_vidx PAIR_HI [PAIRS] = '{
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd4, 3'd5,
        3'd3, 3'd4, 3'd5,
        3'd4, 3'd5,
        3'd5
    };

    // One reachability round: add every neighbor of the reached set.
    function automatic t_vset f_grow(t_vset reach, t_emask mask);
        t_vset nx;
        nx = reach;
        for (int k = 0; k < PAIRS; k++) begin
            if (mask[k]) begin
                if (reach[PAIR_LO[k]]) nx[PAIR_HI[k]] = 1'b1;
                if (reach[PAIR_HI[k]]) nx[PAIR_LO[k]] = 1'b1;
            end
        end
        return nx;
    endfunction

endpackage

// ===== rtl/core/mbc_if.sv =====
interface mbc_in_if;
    logic                       valid;
    logic                       ready;
    logic [mbc_pkg::IN_W-1:0]   packed_multiplicities;

    modport source (output valid, output packed_multiplicities, input ready);
    modport sink   (input valid, input packed_multiplicities, output ready);
endinterface

interface mbc_out_if;
    logic valid;
    logic ready;
    logic is_connected;
    logic is_bridgeless;

    modport source (output valid, output is_connected, output is_bridgeless, input ready);
    modport sink   (input valid, input is_connected, input is_bridgeless, output ready);
endinterface

// ===== rtl/core/multigraph_bridgeless_check_top.sv =====
// Throughput: one word per cycle; the pipeline stalls as a whole only
// while a result waits at the output with ready low.
// Reset: synchronous, active low; clears the stage valid bits only,
// no clearing pass, input ready right after reset.
module multigraph_bridgeless_check_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbc_in_if.sink        i_in,
    mbc_out_if.source     o_out
);

    // Sixteen lanes run the same closure: lane 0 on the full edge set,
    // lane k+1 on the edge set with pair k dropped when that pair holds a
    // single copy. Pairs with no copy or several copies leave the set
    // unchanged, so such lanes simply repeat lane 0.
    //
    // Stage 1: decode counts into per-lane edge masks.
    // Stage 2: reachability rounds 1 and 2.
    // Stage 3: reachability rounds 3 and 4.
    // Stage 4: round 5, full-set test, result word.

    logic w_adv;

    logic                   r_v1, r_v2, r_v3, r_v4;
    mbc_pkg::t_emask        r_mask1 [mbc_pkg::LANES];
    mbc_pkg::t_emask        r_mask2 [mbc_pkg::LANES];
    mbc_pkg::t_emask        r_mask3 [mbc_pkg::LANES];
    mbc_pkg::t_vset         r_reach2 [mbc_pkg::LANES];
    mbc_pkg::t_vset         r_reach3 [mbc_pkg::LANES];
    logic                   r_conn;
    logic                   r_bridge;

    mbc_pkg::t_emask        n_mask1 [mbc_pkg::LANES];
    mbc_pkg::t_vset         n_reach2 [mbc_pkg::LANES];
    mbc_pkg::t_vset         n_reach3 [mbc_pkg::LANES];
    logic                   n_conn;
    logic                   n_bridge;

    // Advance every stage unless a finished word is stuck at the output.
    assign w_adv       = !r_v4 || o_out.ready;
    assign i_in.ready  = w_adv;

    assign o_out.valid         = r_v4;
    assign o_out.is_connected  = r_conn;
    assign o_out.is_bridgeless = r_bridge;

    // Stage 1 logic: present and single-copy masks, then lane masks.
    always_comb begin
        mbc_pkg::t_emask present;
        mbc_pkg::t_emask single;
        logic [mbc_pkg::CNT_W-1:0] cnt;
        for (int k = 0; k < mbc_pkg::PAIRS; k++) begin
            cnt        = i_in.packed_multiplicities[mbc_pkg::CNT_W*k +: mbc_pkg::CNT_W];
            present[k] = |cnt;
            single[k]  = (cnt == mbc_pkg::CNT_W'(1));
        end
        n_mask1[0] = present;
        for (int k = 0; k < mbc_pkg::PAIRS; k++) begin
            n_mask1[k+1] = single[k] ? (present & ~(mbc_pkg::t_emask'(1) << k)) : present;
        end
    end

    // Stages 2 and 3: two closure rounds each.
    always_comb begin
        for (int l = 0; l < mbc_pkg::LANES; l++) begin
            n_reach2[l] = mbc_pkg::f_grow(mbc_pkg::f_grow(mbc_pkg::ROOT_VERT, r_mask1[l]),
                                          r_mask1[l]);
            n_reach3[l] = mbc_pkg::f_grow(mbc_pkg::f_grow(r_reach2[l], r_mask2[l]),
                                          r_mask2[l]);
        end
    end

    // Stage 4: last round, then test for all vertices reached.
    always_comb begin
        logic all_full;
        all_full = 1'b1;
        for (int l = 0; l < mbc_pkg::LANES; l++) begin
            if (mbc_pkg::f_grow(r_reach3[l], r_mask3[l]) != mbc_pkg::ALL_VERTS) begin
                all_full = 1'b0;
            end
        end
        n_conn   = (mbc_pkg::f_grow(r_reach3[0], r_mask3[0]) == mbc_pkg::ALL_VERTS);
        n_bridge = n_conn && all_full;
    end

    // Valid bits: cleared by reset, move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload: no reset, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < mbc_pkg::LANES; l++) begin
                r_mask1[l]  <= n_mask1[l];
                r_mask2[l]  <= r_mask1[l];
                r_mask3[l]  <= r_mask2[l];
                r_reach2[l] <= n_reach2[l];
                r_reach3[l] <= n_reach3[l];
            end
            r_conn   <= n_conn;
            r_bridge <= n_bridge;
        end
    end

endmodule

// ===== rtl/core/mbc_checker.sv =====
module mbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_conn,
    input logic i_out_bridge
);

    // A bridgeless result must also report connected.
    a_bridge_needs_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_conn || !i_out_bridge))
        else $error("bridgeless reported on a disconnected graph");

    // With the output empty the pipeline must take input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output");

    // An input word can only be held off by a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_conn) && $stable(i_out_bridge)))
        else $error("stalled result word changed");

endmodule

bind multigraph_bridgeless_check_top mbc_checker u_mbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_conn   (o_out.is_connected),
    .i_out_bridge (o_out.is_bridgeless)
);
